[rtl/triangle_halfspace_clip_unit_defines.svh]
// assertion helpers used by the checker file
`ifndef TRIANGLE_HALFSPACE_CLIP_UNIT_DEFINES_SVH
`define TRIANGLE_HALFSPACE_CLIP_UNIT_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define THC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clip unit assertion failed");

// consequent checked in the same cycle as the antecedent
`define THC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clip unit assertion failed");

`endif

[rtl/thc_pkg.sv]
`default_nettype none
package thc_pkg;

    localparam int COORD_W    = 32;
    localparam int NRM_W      = 18;
    localparam int TOL_W      = 31;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = COORD_W + NRM_W;
    localparam int DSUM_W     = PROD_W + 2;
    localparam int SAT_W      = DSUM_W - FRAC_W;
    localparam int PROJ_W     = COORD_W + 3;
    localparam int NUM_W      = 2 * COORD_W;
    localparam int DEN_W      = COORD_W + 1;
    localparam int DIV_STEP   = 2;
    localparam int DIV_CYCLES = COORD_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TOL_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord [2:0] t_vec;
    typedef logic signed [NRM_W-1:0] t_ncomp;
    typedef t_ncomp [2:0] t_nrm;
    typedef logic [1:0] t_vidx;

    localparam t_ncomp NRM_X_RESET = t_ncomp'(0);
    localparam t_ncomp NRM_Y_RESET = t_ncomp'(65536);
    localparam t_ncomp NRM_Z_RESET = t_ncomp'(0);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X  = 2'd0,
        CFG_NORMAL_Y  = 2'd1,
        CFG_NORMAL_Z  = 2'd2,
        CFG_TOLERANCE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_WHOLE = 2'd0,
        KIND_CLIP  = 2'd1,
        KIND_SEG   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        SRC_ZERO = 3'd0,
        SRC_A    = 3'd1,
        SRC_B    = 3'd2,
        SRC_C    = 3'd3,
        SRC_CUT1 = 3'd4,
        SRC_CUT2 = 3'd5
    } t_src;

    typedef struct packed {
        t_kind kind;
        t_src  s0;
        t_src  s1;
        t_src  s2;
    } t_piece;

    typedef struct packed {
        logic [1:0]   npieces;
        logic         need_cut;
        t_vidx        c1_a;
        t_vidx        c1_b;
        t_vidx        c2_a;
        t_vidx        c2_b;
        t_piece [2:0] piece;
    } t_plan;

    typedef struct packed {
        t_vec   p0;
        t_coord d0;
        t_vec   p1;
        t_coord d1;
    } t_cut_op;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        t_kind kind;
        t_vec  p0;
        t_vec  p1;
        t_vec  p2;
        logic  last;
    } t_result;

    function automatic t_coord sat_coord(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-COORD_W:0] hi;
        hi = v[SAT_W-1:COORD_W-1];
        if ((&hi) || !(|hi)) begin
            return v[COORD_W-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    function automatic t_src vsrc(input t_vidx i);
        case (i)
            2'd0:    return SRC_A;
            2'd1:    return SRC_B;
            default: return SRC_C;
        endcase
    endfunction

    function automatic t_piece mk_piece(input t_kind k, input t_src a, input t_src b,
                                        input t_src c);
        t_piece p;
        p.kind = k;
        p.s0   = a;
        p.s1   = b;
        p.s2   = c;
        return p;
    endfunction

endpackage
`default_nettype wire

[rtl/triangle_halfspace_clip_unit.sv]
// triangle clipper against the half space on the positive side of a plane
// through the origin
// input channel: one beat carries a triangle (three q16.16 vertices a, b, c);
// a beat is taken when i_in_valid is high and o_in_stall is low
// output channel: each beat is one piece (whole triangle, clipped triangle or
// section segment); o_last_piece marks the final beat of a triangle, and a
// triangle that leaves nothing gives no beat
// configuration: normal x/y/z and tolerance written over the cfg channel,
// always ready; the user must write them only while the block is idle,
// which the block itself does not enforce; a triangle passes the product,
// dot, plan, piece and output registers, and when a cut is needed it waits
// in the plan register for three cut lanes per cut point, which run a 2 bit
// per cycle divider; one triangle with a cut is taken per lane run
// throughput: a triangle holds the piece stage until its last piece has
// gone, and the next enters only once that stage is empty; a triangle that
// leaves nothing passes at one per cycle while the piece stage is empty
// reset clears all valid flags; registers return to normal (0, 1.0, 0) and
// tolerance 1
// a stalled output holds its beat; the pipeline fills behind it and then
// raises o_in_stall
`default_nettype none
module triangle_halfspace_clip_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [31:0]                i_a_x,
    input  logic signed [31:0]                i_a_y,
    input  logic signed [31:0]                i_a_z,
    input  logic signed [31:0]                i_b_x,
    input  logic signed [31:0]                i_b_y,
    input  logic signed [31:0]                i_b_z,
    input  logic signed [31:0]                i_c_x,
    input  logic signed [31:0]                i_c_y,
    input  logic signed [31:0]                i_c_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_piece_kind,
    output logic signed [31:0]                o_p0_x,
    output logic signed [31:0]                o_p0_y,
    output logic signed [31:0]                o_p0_z,
    output logic signed [31:0]                o_p1_x,
    output logic signed [31:0]                o_p1_y,
    output logic signed [31:0]                o_p1_z,
    output logic signed [31:0]                o_p2_x,
    output logic signed [31:0]                o_p2_y,
    output logic signed [31:0]                o_p2_z,
    output logic                              o_last_piece,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [thc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [thc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    thc_pkg::t_nrm               r_nrm;
    logic [thc_pkg::TOL_W-1:0]   r_tol;
    logic                        r_p_valid, r_d_valid;
    logic                        w_accept, w_d_load, w_w_load, w_p_free, w_d_free, w_w_free;
    thc_pkg::t_vec [2:0]         w_vtx_in, w_vtx_d;
    thc_pkg::t_coord [2:0]       w_dot;
    thc_pkg::t_cut_op [1:0]      w_cut_op;
    thc_pkg::t_lane_ctl          w_lane_ctl;
    logic [1:0][2:0]             w_lane_done;
    thc_pkg::t_vec [1:0]         w_cut_res;
    thc_pkg::t_result            w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm[0] <= thc_pkg::NRM_X_RESET;
            r_nrm[1] <= thc_pkg::NRM_Y_RESET;
            r_nrm[2] <= thc_pkg::NRM_Z_RESET;
            r_tol    <= thc_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            case (thc_pkg::t_cfg_idx'(i_cfg_index))
                thc_pkg::CFG_NORMAL_X:  r_nrm[0] <= i_cfg_data[thc_pkg::NRM_W-1:0];
                thc_pkg::CFG_NORMAL_Y:  r_nrm[1] <= i_cfg_data[thc_pkg::NRM_W-1:0];
                thc_pkg::CFG_NORMAL_Z:  r_nrm[2] <= i_cfg_data[thc_pkg::NRM_W-1:0];
                thc_pkg::CFG_TOLERANCE: r_tol    <= i_cfg_data[thc_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // two front stages: products, then saturated dot products
    assign w_w_load   = r_d_valid && w_w_free;
    assign w_d_free   = !r_d_valid || w_w_load;
    assign w_d_load   = r_p_valid && w_d_free;
    assign w_p_free   = !r_p_valid || w_d_load;
    assign o_in_stall = !w_p_free;
    assign w_accept   = i_in_valid && w_p_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_p_valid <= 1'b1;
            end else if (w_d_load) begin
                r_p_valid <= 1'b0;
            end
            if (w_d_load) begin
                r_d_valid <= 1'b1;
            end else if (w_w_load) begin
                r_d_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        w_vtx_in[0][0] = i_a_x;
        w_vtx_in[0][1] = i_a_y;
        w_vtx_in[0][2] = i_a_z;
        w_vtx_in[1][0] = i_b_x;
        w_vtx_in[1][1] = i_b_y;
        w_vtx_in[1][2] = i_b_z;
        w_vtx_in[2][0] = i_c_x;
        w_vtx_in[2][1] = i_c_y;
        w_vtx_in[2][2] = i_c_z;
    end

    for (genvar gv = 0; gv < 3; gv++) begin : g_dot
        thc_dot_lane u_dot (
            .i_clk    (i_clk),
            .i_load_p (w_accept),
            .i_load_d (w_d_load),
            .i_vtx    (w_vtx_in[gv]),
            .i_nrm    (r_nrm),
            .o_vtx    (w_vtx_d[gv]),
            .o_dot    (w_dot[gv])
        );
    end

    for (genvar gc = 0; gc < 2; gc++) begin : g_cut
        for (genvar gj = 0; gj < 3; gj++) begin : g_comp
            thc_cut_lane u_cut (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_lane_ctl),
                .i_p0    (w_cut_op[gc].p0[gj]),
                .i_p1    (w_cut_op[gc].p1[gj]),
                .i_n     (r_nrm[gj]),
                .i_d0    (w_cut_op[gc].d0),
                .i_d1    (w_cut_op[gc].d1),
                .o_done  (w_lane_done[gc][gj]),
                .o_res   (w_cut_res[gc][gj])
            );
        end
    end

    thc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_w_load),
        .i_vtx       (w_vtx_d),
        .i_dot       (w_dot),
        .i_tol       (r_tol),
        .o_w_free    (w_w_free),
        .o_cut_op    (w_cut_op),
        .o_lane_ctl  (w_lane_ctl),
        .i_cut_done  (&w_lane_done),
        .i_cut_res   (w_cut_res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (w_res)
    );

    assign o_piece_kind = w_res.kind;
    assign o_p0_x       = w_res.p0[0];
    assign o_p0_y       = w_res.p0[1];
    assign o_p0_z       = w_res.p0[2];
    assign o_p1_x       = w_res.p1[0];
    assign o_p1_y       = w_res.p1[1];
    assign o_p1_z       = w_res.p1[2];
    assign o_p2_x       = w_res.p2[0];
    assign o_p2_y       = w_res.p2[1];
    assign o_p2_z       = w_res.p2[2];
    assign o_last_piece = w_res.last;

endmodule
`default_nettype wire

[rtl/thc_dot_lane.sv]
`default_nettype none
module thc_dot_lane (
    input  logic           i_clk,
    input  logic           i_load_p,
    input  logic           i_load_d,
    input  thc_pkg::t_vec  i_vtx,
    input  thc_pkg::t_nrm  i_nrm,
    output thc_pkg::t_vec  o_vtx,
    output thc_pkg::t_coord o_dot
);

    logic signed [thc_pkg::PROD_W-1:0] r_prod [3];
    thc_pkg::t_vec                     r_vtx_p;
    thc_pkg::t_vec                     r_vtx_d;
    thc_pkg::t_coord                   r_dot;
    logic signed [thc_pkg::DSUM_W-1:0] w_sum;
    thc_pkg::t_coord                   n_dot;

    always_comb begin
        w_sum = {{2{r_prod[0][thc_pkg::PROD_W-1]}}, r_prod[0]}
              + {{2{r_prod[1][thc_pkg::PROD_W-1]}}, r_prod[1]}
              + {{2{r_prod[2][thc_pkg::PROD_W-1]}}, r_prod[2]};
        // floor by 2^16 is the upper slice
        n_dot = thc_pkg::sat_coord(w_sum[thc_pkg::DSUM_W-1:thc_pkg::FRAC_W]);
    end

    always_ff @(posedge i_clk) begin
        if (i_load_p) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= $signed(i_nrm[j]) * $signed(i_vtx[j]);
            end
            r_vtx_p <= i_vtx;
        end
        if (i_load_d) begin
            r_dot   <= n_dot;
            r_vtx_d <= r_vtx_p;
        end
    end

    assign o_vtx = r_vtx_d;
    assign o_dot = r_dot;

endmodule
`default_nettype wire

[rtl/thc_cut_lane.sv]
`default_nettype none
module thc_cut_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  thc_pkg::t_lane_ctl i_ctl,
    input  thc_pkg::t_coord    i_p0,
    input  thc_pkg::t_coord    i_p1,
    input  thc_pkg::t_ncomp    i_n,
    input  thc_pkg::t_coord    i_d0,
    input  thc_pkg::t_coord    i_d1,
    output logic               o_done,
    output thc_pkg::t_coord    o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_WGT,
        S_SUM,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

    t_state                            r_state;
    thc_pkg::t_coord                   r_p0, r_p1, r_d0, r_d1;
    thc_pkg::t_ncomp                   r_n;
    logic signed [thc_pkg::PROD_W-1:0] r_m0, r_m1;
    thc_pkg::t_coord                   r_q0;
    logic signed [thc_pkg::NUM_W-1:0]  r_t0, r_t1;
    logic [thc_pkg::DEN_W-1:0]         r_rem, r_den;
    logic [thc_pkg::COORD_W-1:0]       r_quo;
    logic                              r_neg;
    logic [thc_pkg::DIV_CNT_W-1:0]     r_cnt;
    thc_pkg::t_coord                   r_res;

    logic [thc_pkg::COORD_W-1:0]       w_w0, w_w1;
    logic signed [thc_pkg::PROJ_W-1:0] w_diff0, w_diff1;
    thc_pkg::t_coord                   w_q0, w_q1;
    logic signed [thc_pkg::NUM_W:0]    w_t0, w_t1, w_sum;
    logic [thc_pkg::NUM_W-1:0]         w_mag;
    logic [thc_pkg::DEN_W-1:0]         w_den;
    logic [thc_pkg::DEN_W-1:0]         n_rem;
    logic [thc_pkg::COORD_W-1:0]       n_quo;
    logic [thc_pkg::DEN_W:0]           w_trial;
    logic [thc_pkg::COORD_W:0]         w_qext, w_fix;

    always_comb begin
        w_w0 = r_d0[thc_pkg::COORD_W-1] ? thc_pkg::COORD_W'(~r_d0 + 1'b1) : r_d0;
        w_w1 = r_d1[thc_pkg::COORD_W-1] ? thc_pkg::COORD_W'(~r_d1 + 1'b1) : r_d1;

        // projection onto the plane, floor of n*d by 2^16
        w_diff0 = $signed({{3{r_p0[thc_pkg::COORD_W-1]}}, r_p0})
                - $signed({r_m0[thc_pkg::PROD_W-1], r_m0[thc_pkg::PROD_W-1:thc_pkg::FRAC_W]});
        w_diff1 = $signed({{3{r_p1[thc_pkg::COORD_W-1]}}, r_p1})
                - $signed({r_m1[thc_pkg::PROD_W-1], r_m1[thc_pkg::PROD_W-1:thc_pkg::FRAC_W]});
        w_q0 = thc_pkg::sat_coord({w_diff0[thc_pkg::PROJ_W-1], w_diff0});
        w_q1 = thc_pkg::sat_coord({w_diff1[thc_pkg::PROJ_W-1], w_diff1});

        // cross weighting
        w_t0 = $signed(w_q0) * $signed({1'b0, w_w1});
        w_t1 = $signed(w_q1) * $signed({1'b0, w_w0});

        w_sum = $signed({r_t0[thc_pkg::NUM_W-1], r_t0})
              + $signed({r_t1[thc_pkg::NUM_W-1], r_t1});
        w_mag = w_sum[thc_pkg::NUM_W] ? thc_pkg::NUM_W'(~w_sum + 1'b1)
                                      : w_sum[thc_pkg::NUM_W-1:0];
        w_den = {1'b0, w_w0} + {1'b0, w_w1};

        // restoring division, a few quotient bits per cycle
        n_rem   = r_rem;
        n_quo   = r_quo;
        w_trial = '0;
        for (int k = 0; k < thc_pkg::DIV_STEP; k++) begin
            w_trial = {n_rem, n_quo[thc_pkg::COORD_W-1]};
            n_quo   = {n_quo[thc_pkg::COORD_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem    = thc_pkg::DEN_W'(w_trial - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_trial[thc_pkg::DEN_W-1:0];
            end
        end

        // floor for negative numerators
        w_qext = {1'b0, r_quo};
        w_fix  = r_neg ? (~w_qext + 1'b1 - (thc_pkg::COORD_W+1)'(r_rem != '0)) : w_qext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_state <= S_WGT;
                end
                S_WGT: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (w_den == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == thc_pkg::DIV_CNT_W'(thc_pkg::DIV_CYCLES - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_ctl.start) begin
                        r_state <= S_PROD;
                    end else if (i_ctl.ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        if (i_ctl.start) begin
            r_p0 <= i_p0;
            r_p1 <= i_p1;
            r_n  <= i_n;
            r_d0 <= i_d0;
            r_d1 <= i_d1;
        end
        if (r_state == S_PROD) begin
            r_m0 <= $signed(r_n) * $signed(r_d0);
            r_m1 <= $signed(r_n) * $signed(r_d1);
        end
        if (r_state == S_WGT) begin
            r_q0 <= w_q0;
            r_t0 <= w_t0[thc_pkg::NUM_W-1:0];
            r_t1 <= w_t1[thc_pkg::NUM_W-1:0];
        end
        if (r_state == S_SUM) begin
            r_neg <= w_sum[thc_pkg::NUM_W];
            r_rem <= {1'b0, w_mag[thc_pkg::NUM_W-1:thc_pkg::COORD_W]};
            r_quo <= w_mag[thc_pkg::COORD_W-1:0];
            r_den <= w_den;
            r_cnt <= '0;
            r_res <= r_q0;
        end
        if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == S_FIX) begin
            r_res <= w_fix[thc_pkg::COORD_W-1:0];
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule
`default_nettype wire

[rtl/thc_merge.sv]
`default_nettype none
module thc_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  thc_pkg::t_vec [2:0]       i_vtx,
    input  thc_pkg::t_coord [2:0]     i_dot,
    input  logic [thc_pkg::TOL_W-1:0] i_tol,
    output logic                      o_w_free,
    output thc_pkg::t_cut_op [1:0]    o_cut_op,
    output thc_pkg::t_lane_ctl        o_lane_ctl,
    input  logic                      i_cut_done,
    input  thc_pkg::t_vec [1:0]       i_cut_res,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output thc_pkg::t_result          o_res
);

    logic [2:0]           c_ins, c_onp, c_neg;
    logic [1:0]           c_n_in, c_n_on;
    logic [thc_pkg::COORD_W-1:0] c_mag [3];
    thc_pkg::t_vidx       c_n, c_m, c_o0, c_o1, c_lone, c_tmp;
    logic                 c_s01, c_s12;
    thc_pkg::t_plan       c_plan;

    logic                 r_w_valid;
    thc_pkg::t_plan       r_w_plan;
    thc_pkg::t_vec [2:0]  r_w_vtx;
    logic                 w_leave;

    logic                 r_e_valid;
    thc_pkg::t_plan       r_e_plan;
    thc_pkg::t_vec [2:0]  r_e_vtx;
    thc_pkg::t_vec [1:0]  r_e_cut;
    logic [1:0]           r_e_idx;
    logic                 w_e_load, w_e_last;
    thc_pkg::t_piece      w_piece;
    thc_pkg::t_result     n_res;

    logic                 r_o_valid;
    thc_pkg::t_result     r_o_res;

    function automatic thc_pkg::t_vec pick(input thc_pkg::t_src s,
                                           input thc_pkg::t_vec [2:0] v,
                                           input thc_pkg::t_vec [1:0] c);
        case (s)
            thc_pkg::SRC_A:    return v[0];
            thc_pkg::SRC_B:    return v[1];
            thc_pkg::SRC_C:    return v[2];
            thc_pkg::SRC_CUT1: return c[0];
            thc_pkg::SRC_CUT2: return c[1];
            default:           return '0;
        endcase
    endfunction

    // vertex classification and piece plan
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_neg[i] = i_dot[i][thc_pkg::COORD_W-1];
            c_ins[i] = !c_neg[i] && (i_dot[i] != '0);
            c_mag[i] = c_neg[i] ? thc_pkg::COORD_W'(~i_dot[i] + 1'b1) : i_dot[i];
            c_onp[i] = c_mag[i] < {1'b0, i_tol};
        end
        c_n_in = {1'b0, c_ins[0]} + {1'b0, c_ins[1]} + {1'b0, c_ins[2]};
        c_n_on = {1'b0, c_onp[0]} + {1'b0, c_onp[1]} + {1'b0, c_onp[2]};
        c_s01  = (c_ins[0] && c_ins[1]) || (c_neg[0] && c_neg[1]);
        c_s12  = (c_ins[1] && c_ins[2]) || (c_neg[1] && c_neg[2]);

        c_n    = !c_onp[0] ? 2'd0 : (!c_onp[1] ? 2'd1 : 2'd2);
        c_m    = c_onp[0] ? 2'd0 : (c_onp[1] ? 2'd1 : 2'd2);
        c_lone = c_s01 ? 2'd2 : (c_s12 ? 2'd0 : 2'd1);
        c_o0   = '0;
        c_o1   = '0;
        c_tmp  = '0;
        c_plan = '0;

        if (c_n_in == 2'd0 || c_n_on == 2'd3) begin
            c_plan.npieces = 2'd0;
        end else if (c_n_on == 2'd2) begin
            c_o0 = (c_n == 2'd0) ? 2'd1 : 2'd0;
            c_o1 = (c_n == 2'd2) ? 2'd1 : 2'd2;
            if (c_ins[c_n]) begin
                c_plan.npieces  = 2'd2;
                c_plan.piece[0] = thc_pkg::mk_piece(thc_pkg::KIND_WHOLE, thc_pkg::SRC_A,
                                                    thc_pkg::SRC_B, thc_pkg::SRC_C);
                c_plan.piece[1] = thc_pkg::mk_piece(thc_pkg::KIND_SEG, thc_pkg::vsrc(c_o0),
                                                    thc_pkg::vsrc(c_o1), thc_pkg::SRC_ZERO);
            end
        end else if (c_n_on == 2'd1) begin
            c_o0 = (c_m == 2'd0) ? 2'd1 : 2'd0;
            c_o1 = (c_m == 2'd2) ? 2'd1 : 2'd2;
            if (c_ins[c_o0] && c_ins[c_o1]) begin
                c_plan.npieces  = 2'd1;
                c_plan.piece[0] = thc_pkg::mk_piece(thc_pkg::KIND_WHOLE, thc_pkg::SRC_A,
                                                    thc_pkg::SRC_B, thc_pkg::SRC_C);
            end else if (c_ins[c_o0] || c_ins[c_o1]) begin
                if (!c_ins[c_o0]) begin
                    c_tmp = c_o0;
                    c_o0  = c_o1;
                    c_o1  = c_tmp;
                end
                c_plan.need_cut = 1'b1;
                c_plan.c1_a     = c_o0;
                c_plan.c1_b     = c_o1;
                c_plan.npieces  = 2'd2;
                c_plan.piece[0] = thc_pkg::mk_piece(thc_pkg::KIND_CLIP, thc_pkg::vsrc(c_m),
                                                    thc_pkg::vsrc(c_o0), thc_pkg::SRC_CUT1);
                c_plan.piece[1] = thc_pkg::mk_piece(thc_pkg::KIND_SEG, thc_pkg::SRC_CUT1,
                                                    thc_pkg::vsrc(c_m), thc_pkg::SRC_ZERO);
            end
        end else if (c_n_in == 2'd3) begin
            c_plan.npieces  = 2'd1;
            c_plan.piece[0] = thc_pkg::mk_piece(thc_pkg::KIND_WHOLE, thc_pkg::SRC_A,
                                                thc_pkg::SRC_B, thc_pkg::SRC_C);
        end else begin
            c_o0 = (c_lone == 2'd0) ? 2'd1 : 2'd0;
            c_o1 = (c_lone == 2'd2) ? 2'd1 : 2'd2;
            c_plan.need_cut = 1'b1;
            c_plan.c1_a     = c_lone;
            c_plan.c1_b     = c_o0;
            c_plan.c2_a     = c_lone;
            c_plan.c2_b     = c_o1;
            if (c_n_in == 2'd1) begin
                c_plan.npieces  = 2'd2;
                c_plan.piece[0] = thc_pkg::mk_piece(thc_pkg::KIND_CLIP, thc_pkg::vsrc(c_lone),
                                                    thc_pkg::SRC_CUT1, thc_pkg::SRC_CUT2);
                c_plan.piece[1] = thc_pkg::mk_piece(thc_pkg::KIND_SEG, thc_pkg::SRC_CUT1,
                                                    thc_pkg::SRC_CUT2, thc_pkg::SRC_ZERO);
            end else begin
                c_plan.npieces  = 2'd3;
                c_plan.piece[0] = thc_pkg::mk_piece(thc_pkg::KIND_CLIP, thc_pkg::vsrc(c_o0),
                                                    thc_pkg::vsrc(c_o1), thc_pkg::SRC_CUT1);
                c_plan.piece[1] = thc_pkg::mk_piece(thc_pkg::KIND_CLIP, thc_pkg::vsrc(c_o1),
                                                    thc_pkg::SRC_CUT1, thc_pkg::SRC_CUT2);
                c_plan.piece[2] = thc_pkg::mk_piece(thc_pkg::KIND_SEG, thc_pkg::SRC_CUT1,
                                                    thc_pkg::SRC_CUT2, thc_pkg::SRC_ZERO);
            end
        end
    end

    always_comb begin
        o_cut_op[0].p0 = i_vtx[c_plan.c1_a];
        o_cut_op[0].d0 = i_dot[c_plan.c1_a];
        o_cut_op[0].p1 = i_vtx[c_plan.c1_b];
        o_cut_op[0].d1 = i_dot[c_plan.c1_b];
        o_cut_op[1].p0 = i_vtx[c_plan.c2_a];
        o_cut_op[1].d0 = i_dot[c_plan.c2_a];
        o_cut_op[1].p1 = i_vtx[c_plan.c2_b];
        o_cut_op[1].d1 = i_dot[c_plan.c2_b];
    end

    assign w_leave          = r_w_valid && !r_e_valid && (!r_w_plan.need_cut || i_cut_done);
    assign o_w_free         = !r_w_valid || w_leave;
    assign o_lane_ctl.start = i_load && c_plan.need_cut;
    assign o_lane_ctl.ack   = w_leave && r_w_plan.need_cut;

    always_comb begin
        w_piece    = r_e_plan.piece[r_e_idx];
        w_e_last   = (r_e_idx == r_e_plan.npieces - 2'd1);
        w_e_load   = r_e_valid && (!r_o_valid || !i_out_stall);
        n_res.kind = w_piece.kind;
        n_res.p0   = pick(w_piece.s0, r_e_vtx, r_e_cut);
        n_res.p1   = pick(w_piece.s1, r_e_vtx, r_e_cut);
        n_res.p2   = pick(w_piece.s2, r_e_vtx, r_e_cut);
        n_res.last = w_e_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_e_idx   <= '0;
        end else begin
            if (i_load) begin
                r_w_valid <= 1'b1;
            end else if (w_leave) begin
                r_w_valid <= 1'b0;
            end

            if (w_leave && r_w_plan.npieces != 2'd0) begin
                r_e_valid <= 1'b1;
                r_e_idx   <= '0;
            end else if (w_e_load) begin
                if (w_e_last) begin
                    r_e_valid <= 1'b0;
                end else begin
                    r_e_idx <= r_e_idx + 1'b1;
                end
            end

            if (w_e_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end

        if (i_load) begin
            r_w_plan <= c_plan;
            r_w_vtx  <= i_vtx;
        end
        if (w_leave) begin
            r_e_plan <= r_w_plan;
            r_e_vtx  <= r_w_vtx;
            r_e_cut  <= i_cut_res;
        end
        if (w_e_load) begin
            r_o_res <= n_res;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_res       = r_o_res;

endmodule
`default_nettype wire

[rtl/thc_checker.sv]
`default_nettype none
`include "triangle_halfspace_clip_unit_defines.svh"
module thc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_piece_kind,
    input logic signed [31:0] o_p0_x,
    input logic signed [31:0] o_p1_x,
    input logic signed [31:0] o_p2_x,
    input logic signed [31:0] o_p2_y,
    input logic signed [31:0] o_p2_z,
    input logic               o_last_piece
);

    // stalled beat holds
    `THC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_piece_kind) && $stable(o_p0_x) && $stable(o_p1_x) && $stable(o_last_piece))

    // a section segment has no third point
    `THC_ASSERT_NOW(a_seg_p2_zero, i_clk, i_rst_n, o_out_valid && (o_piece_kind == thc_pkg::KIND_SEG), (o_p2_x == 0) && (o_p2_y == 0) && (o_p2_z == 0))

    // the segment always closes a triangle
    `THC_ASSERT_NOW(a_seg_last, i_clk, i_rst_n, o_out_valid && (o_piece_kind == thc_pkg::KIND_SEG), o_last_piece)

endmodule

bind triangle_halfspace_clip_unit thc_checker u_thc_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    typedef logic signed [31:0] t_coord;
    typedef struct {
        logic [1:0] kind;
        t_coord     p [9];
        logic       last;
    } t_piece;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_coord i_a_x = '0, i_a_y = '0, i_a_z = '0;
    t_coord i_b_x = '0, i_b_y = '0, i_b_z = '0;
    t_coord i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [1:0] o_piece_kind;
    t_coord o_p0_x, o_p0_y, o_p0_z, o_p1_x, o_p1_y, o_p1_z, o_p2_x, o_p2_y, o_p2_z;
    logic o_last_piece;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [thc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [thc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    triangle_halfspace_clip_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    longint nrm [3];
    longint tol;
    t_piece pieces_due [$];
    int errors = 0;
    int hold_off = 0;
    bit stall_random = 1'b1;
    longint cycles = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic longint fl16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint plane_dist(longint p [3]);
        return sat(fl16(nrm[0] * p[0] + nrm[1] * p[1] + nrm[2] * p[2]));
    endfunction

    task automatic crossing(input longint p0 [3], input longint d0,
                            input longint p1 [3], input longint d1, output longint r [3]);
        longint w0, w1, den, q0, q1, num, q;
        w0 = magn(d0);
        w1 = magn(d1);
        den = w0 + w1;
        for (int i = 0; i < 3; i++) begin
            q0 = sat(p0[i] - fl16(nrm[i] * d0));
            q1 = sat(p1[i] - fl16(nrm[i] * d1));
            if (den == 0) begin
                r[i] = q0;
            end else begin
                num = q0 * w1 + q1 * w0;
                q = num / den;
                if (num % den != 0 && num < 0) q -= 1;
                r[i] = q;
            end
        end
    endtask

    task automatic push_piece(input logic [1:0] k, input longint a [3], input longint b [3],
                              input longint c [3], input bit has_c);
        t_piece pc;
        pc.kind = k;
        for (int i = 0; i < 3; i++) begin
            pc.p[i] = t_coord'(a[i]);
            pc.p[3 + i] = t_coord'(b[i]);
            pc.p[6 + i] = has_c ? t_coord'(c[i]) : '0;
        end
        pc.last = 1'b0;
        pieces_due.insert(pieces_due.size(), pc);
    endtask

    task automatic predict_clip(input t_coord t [9]);
        longint v [3][3];
        longint d [3];
        longint c1 [3], c2 [3], z [3];
        bit ins [3], onp [3];
        int n_in, n_on, base, m, o0, o1, n, lone, tmp;
        n_in = 0;
        n_on = 0;
        base = pieces_due.size();
        z = '{0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) v[i][j] = t[i * 3 + j];
            d[i] = plane_dist(v[i]);
            ins[i] = d[i] > 0;
            onp[i] = magn(d[i]) < tol;
            n_in += ins[i];
            n_on += onp[i];
        end
        if (n_in == 0 || n_on == 3) return;
        if (n_on == 2) begin
            n = !onp[0] ? 0 : (!onp[1] ? 1 : 2);
            o0 = n == 0 ? 1 : 0;
            o1 = n == 2 ? 1 : 2;
            if (!ins[n]) return;
            push_piece(thc_pkg::KIND_WHOLE, v[0], v[1], v[2], 1);
            push_piece(thc_pkg::KIND_SEG, v[o0], v[o1], z, 0);
        end else if (n_on == 1) begin
            m = onp[0] ? 0 : (onp[1] ? 1 : 2);
            o0 = m == 0 ? 1 : 0;
            o1 = m == 2 ? 1 : 2;
            if (!ins[o0] && !ins[o1]) return;
            if (ins[o0] && ins[o1]) begin
                push_piece(thc_pkg::KIND_WHOLE, v[0], v[1], v[2], 1);
            end else begin
                if (!ins[o0]) begin
                    tmp = o0; o0 = o1; o1 = tmp;
                end
                crossing(v[o0], d[o0], v[o1], d[o1], c1);
                push_piece(thc_pkg::KIND_CLIP, v[m], v[o0], c1, 1);
                push_piece(thc_pkg::KIND_SEG, c1, v[m], z, 0);
            end
        end else if (n_in == 3) begin
            push_piece(thc_pkg::KIND_WHOLE, v[0], v[1], v[2], 1);
        end else begin
            if ((d[0] > 0 && d[1] > 0) || (d[0] < 0 && d[1] < 0)) lone = 2;
            else if ((d[1] > 0 && d[2] > 0) || (d[1] < 0 && d[2] < 0)) lone = 0;
            else lone = 1;
            o0 = lone == 0 ? 1 : 0;
            o1 = lone == 2 ? 1 : 2;
            crossing(v[lone], d[lone], v[o0], d[o0], c1);
            crossing(v[lone], d[lone], v[o1], d[o1], c2);
            if (n_in == 1) begin
                push_piece(thc_pkg::KIND_CLIP, v[lone], c1, c2, 1);
            end else begin
                push_piece(thc_pkg::KIND_CLIP, v[o0], v[o1], c1, 1);
                push_piece(thc_pkg::KIND_CLIP, v[o1], c1, c2, 1);
            end
            push_piece(thc_pkg::KIND_SEG, c1, c2, z, 0);
        end
        if (pieces_due.size() > base) pieces_due[$].last = 1'b1;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_triangle(input t_coord t [9]);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_a_x, i_a_y, i_a_z} <= {t[0], t[1], t[2]};
        {i_b_x, i_b_y, i_b_z} <= {t[3], t[4], t[5]};
        {i_c_x, i_c_y, i_c_z} <= {t[6], t[7], t[8]};
        do @(posedge i_clk); while (o_in_stall);
        predict_clip(t);
    endtask

    task automatic write_reg(input thc_pkg::t_cfg_idx idx, input longint val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= thc_pkg::CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            thc_pkg::CFG_NORMAL_X: nrm[0] = longint'($signed(thc_pkg::NRM_W'(val)));
            thc_pkg::CFG_NORMAL_Y: nrm[1] = longint'($signed(thc_pkg::NRM_W'(val)));
            thc_pkg::CFG_NORMAL_Z: nrm[2] = longint'($signed(thc_pkg::NRM_W'(val)));
            thc_pkg::CFG_TOLERANCE: tol = val & 64'h7fff_ffff;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pieces_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_plane(input longint nx, input longint ny, input longint nz,
                             input longint tl);
        drain();
        write_reg(thc_pkg::CFG_NORMAL_X, nx);
        write_reg(thc_pkg::CFG_NORMAL_Y, ny);
        write_reg(thc_pkg::CFG_NORMAL_Z, nz);
        write_reg(thc_pkg::CFG_TOLERANCE, tl);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_coord rnd_coord();
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return t_coord'($signed($urandom_range(0, 8)) - 4);
            default: return t_coord'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic t_coord near_plane(input t_coord c);
        return $urandom_range(0, 1) ? c : t_coord'($signed($urandom_range(0, 6)) - 3);
    endfunction

    task automatic random_triangles(input int count);
        t_coord t [9];
        for (int k = 0; k < count; k++) begin
            for (int i = 0; i < 9; i++) t[i] = rnd_coord();
            // pull some vertices onto the plane y = 0 style band
            if ($urandom_range(0, 2) == 0) t[1] = near_plane(t[1]);
            if ($urandom_range(0, 2) == 0) t[4] = near_plane(t[4]);
            if ($urandom_range(0, 2) == 0) t[7] = near_plane(t[7]);
            send_triangle(t);
        end
    endtask

    task automatic test_directed();
        t_coord t [9];
        t = '{0, 100, 0, 65536, 200, 0, 0, 300, 65536}; send_triangle(t);
        t = '{0, -100, 0, 65536, -200, 0, 0, -300, 5}; send_triangle(t);
        t = '{0, 0, 0, 65536, 0, 0, 0, 0, 65536}; send_triangle(t);
        t = '{0, 0, 0, 65536, 0, 0, 0, 500, 65536}; send_triangle(t);
        t = '{0, 0, 0, 65536, 0, 0, 0, -500, 65536}; send_triangle(t);
        t = '{0, 0, 0, 7, 900, 0, 0, 800, 65536}; send_triangle(t);
        t = '{0, 0, 0, 7, 900, 0, 0, -800, 65536}; send_triangle(t);
        t = '{0, 0, 0, 7, -900, 0, 0, -800, 65536}; send_triangle(t);
        t = '{0, 65536, 0, 65536, -65536, 0, 0, -131072, 65536}; send_triangle(t);
        t = '{0, 65536, 0, 65536, 131072, 0, 0, -131072, 65536}; send_triangle(t);
        t = '{5, -65536, 0, 65536, 65536, 3, 0, -131072, 65536}; send_triangle(t);
        t = '{1, 65536, 2, 65536, -65536, 0, 9, 65536, 65536}; send_triangle(t);
        t = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000}; send_triangle(t);
        t = '{-1, -1, -1, -1, 32'sh7fffffff, -1, 32'sh80000000, 32'sh80000000, -1};
        send_triangle(t);
    endtask

    task automatic test_zero_tolerance();
        t_coord t [9];
        set_plane(0, 65536, 0, 0);
        t = '{0, 0, 0, 65536, 100, 0, 0, -100, 65536}; send_triangle(t);
        t = '{0, 0, 0, 65536, 0, 0, 0, 100, 65536}; send_triangle(t);
        t = '{0, 0, 0, 65536, 0, 0, 0, -100, 65536}; send_triangle(t);
        t = '{3, 0, 0, 65536, 0, 9, 0, 0, 65536}; send_triangle(t);
        random_triangles(30);
    endtask

    task automatic test_extreme_normals();
        set_plane(131071, -131072, 131071, 2147483647);
        random_triangles(20);
        set_plane(-131072, 131071, -131072, 65536);
        random_triangles(40);
        set_plane(46341, 46341, 0, 300);
        random_triangles(60);
    endtask

    task automatic test_random_planes();
        for (int p = 0; p < 5; p++) begin
            set_plane($urandom_range(0, 262143), $urandom_range(0, 262143),
                      $urandom_range(0, 262143),
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000));
            random_triangles(40);
        end
    endtask

    task automatic test_backpressure();
        set_plane(0, 0, 65536, 4);
        stall_random = 1'b0;
        hold_off = 300;
        random_triangles(30);
        stall_random = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            i_out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else if (stall_random) begin
            i_out_stall <= gap_len() != 0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_piece w;
        t_coord got [9];
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_p0_x, o_p0_y, o_p0_z, o_p1_x, o_p1_y, o_p1_z, o_p2_x, o_p2_y, o_p2_z};
            if (pieces_due.size() == 0) begin
                report("unexpected beat kind", o_piece_kind, -1);
            end else begin
                w = pieces_due.pop_front();
                if (o_piece_kind !== w.kind) report("piece_kind", o_piece_kind, w.kind);
                for (int i = 0; i < 9; i++)
                    if (got[i] !== w.p[i]) report($sformatf("point field %0d", i), got[i], w.p[i]);
                if (o_last_piece !== w.last) report("last_piece", o_last_piece, w.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        nrm = '{0, 65536, 0};
        tol = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        random_triangles(12);
        test_zero_tolerance();
        test_extreme_normals();
        test_random_planes();
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
